/* rtl/conv3x3_zero_pad_filter_unit_macros.svh */
// Assertion shorthands, clocked on clk_i and held off while rst_ni is low.
`ifndef CONV3X3_ZERO_PAD_FILTER_UNIT_MACROS_SVH
`define CONV3X3_ZERO_PAD_FILTER_UNIT_MACROS_SVH

`define C3ZPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// antecedent now, consequent on the next edge
`define C3ZPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  `C3ZPF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/c3zpf_pkg.sv */
package c3zpf_pkg;

  localparam int unsigned MaxColsDef   = 2048;
  localparam int unsigned MaxRowsDef   = 2048;
  localparam int unsigned PixelBitsDef = 8;

  localparam int unsigned PixInW  = 8;
  localparam int unsigned ValueW  = 13;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [ValueW-1:0] ValueMax = 13'sd4095;
  localparam logic signed [ValueW-1:0] ValueMin = -13'sd4096;

  typedef enum logic [CfgIdxW-1:0] {
    RegFilterSel = 2'd0,
    RegFrameRows = 2'd1,
    RegFrameCols = 2'd2
  } cfg_reg_e;

  localparam logic [1:0] FiltGauss = 2'd0;
  localparam logic [1:0] FiltGradX = 2'd1;
  localparam logic [1:0] FiltGradY = 2'd2;

  localparam logic [1:0]      FilterRst = FiltGauss;
  localparam logic [CfgW-1:0] RowsRst   = 12'd480;
  localparam logic [CfgW-1:0] ColsRst   = 12'd640;

  // queue between the window stage and the kernel stage
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueLvlW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic                 empty;
    logic [QueueLvlW-1:0] level;
  } q_stat_t;

  typedef logic signed [4:0] tap_t;

  // rows top..bottom, columns left..right
  localparam tap_t GaussTaps [3][3] = '{
    '{5'sd1, 5'sd2, 5'sd1},
    '{5'sd2, 5'sd4, 5'sd2},
    '{5'sd1, 5'sd2, 5'sd1}
  };
  localparam tap_t GradXTaps [3][3] = '{
    '{5'sd3,  5'sd0, -5'sd3},
    '{5'sd10, 5'sd0, -5'sd10},
    '{5'sd3,  5'sd0, -5'sd3}
  };
  localparam tap_t GradYTaps [3][3] = '{
    '{5'sd3,  5'sd10,  5'sd3},
    '{5'sd0,  5'sd0,   5'sd0},
    '{-5'sd3, -5'sd10, -5'sd3}
  };

  function automatic tap_t kernel_tap(logic [1:0] sel, int r, int c);
    tap_t t;
    unique case (sel)
      FiltGauss: t = GaussTaps[r][c];
      FiltGradX: t = GradXTaps[r][c];
      FiltGradY: t = GradYTaps[r][c];
      default:   t = '0;
    endcase
    return t;
  endfunction

endpackage

/* rtl/c3zpf_if.sv */
interface c3zpf_pix_if;
  logic                           valid;
  logic                           ready;
  logic [c3zpf_pkg::PixInW-1:0]   pixel;
  logic                           drain;

  modport source (output valid, pixel, drain, input ready);
  modport sink   (input valid, pixel, drain, output ready);
endinterface

interface c3zpf_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [c3zpf_pkg::ValueW-1:0] value;
  logic                                frame_end;

  modport source (output valid, value, frame_end, input ready);
  modport sink   (input valid, value, frame_end, output ready);
endinterface

/* rtl/c3zpf_front.sv */
module c3zpf_front #(
  parameter int unsigned MAX_COLS   = c3zpf_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS   = c3zpf_pkg::MaxRowsDef,
  parameter int unsigned PIXEL_BITS = c3zpf_pkg::PixelBitsDef,
  localparam int unsigned RW   = $clog2(MAX_ROWS + 2),
  localparam int unsigned CNTW = $clog2(MAX_COLS + 1),
  localparam int unsigned DW   = 9 * PIXEL_BITS + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  c3zpf_pix_if.sink           pix_i,
  input  logic [RW-1:0]       rows_i,
  input  logic [CNTW-1:0]     cols_i,
  input  c3zpf_pkg::q_stat_t  q_stat_i,
  output logic                push_o,
  output logic [DW-1:0]       push_data_o
);

  localparam int unsigned AW = $clog2(MAX_COLS);
  localparam int unsigned PW = PIXEL_BITS;
  localparam int unsigned LW = c3zpf_pkg::QueueLvlW + 1;

  typedef struct packed {
    logic emit;
    logic top_en;
    logic bot_en;
    logic left_en;
    logic right_en;
    logic frame_end;
  } tap_ctl_t;

  logic [RW-1:0]   in_row_q, in_row_d;
  logic [AW-1:0]   in_col_q, in_col_d;
  logic [CNTW-1:0] col_ext;
  logic            accept, after_frame, take;
  logic            close_row, mid_row;
  logic [RW-1:0]   orow;
  tap_ctl_t        ctl_d, s1_ctl_q;

  logic            s1_valid_q;
  logic [AW-1:0]   s1_addr_q;
  logic [PW-1:0]   s1_pix_q;

  logic [2*PW-1:0] line_mem [MAX_COLS];
  logic [2*PW-1:0] rd_data_q, byp_data_q, rd_word;
  logic            byp_q;
  logic [PW-1:0]   rd_top, rd_mid;

  logic [PW-1:0]        win_q [3][3];
  logic [PW-1:0]        win_d [3][3];
  logic [2:0]           row_en, col_en;
  logic [8:0][PW-1:0]   taps;

  // credit: queued entries plus the one in the window stage
  assign pix_i.ready = ({1'b0, q_stat_i.level} + LW'(s1_valid_q))
                       < LW'(c3zpf_pkg::QueueDepth);

  assign accept      = pix_i.valid && pix_i.ready;
  assign after_frame = in_row_q >= rows_i;
  // a drain inside the frame is a bubble
  assign take        = accept && (after_frame || !pix_i.drain);
  assign col_ext     = CNTW'(in_col_q);

  // first column closes the last column of the row two above
  assign close_row = (in_col_q == '0) && (in_row_q >= RW'(2));
  assign mid_row   = (in_col_q != '0) && (in_row_q != '0);
  assign orow      = close_row ? in_row_q - RW'(2) : in_row_q - RW'(1);

  always_comb begin
    ctl_d.emit      = close_row || mid_row;
    ctl_d.top_en    = orow != '0;
    ctl_d.bot_en    = (orow + RW'(1)) < rows_i;
    ctl_d.left_en   = close_row ? (cols_i >= CNTW'(2)) : (in_col_q >= AW'(2));
    ctl_d.right_en  = mid_row;
    ctl_d.frame_end = (orow == rows_i - RW'(1)) && (close_row || col_ext == cols_i);
  end

  always_comb begin
    in_row_d = in_row_q;
    in_col_d = in_col_q;
    if (in_row_q >= rows_i + RW'(1)) begin
      in_row_d = '0;
      in_col_d = '0;
    end else if (col_ext + CNTW'(1) >= cols_i) begin
      in_row_d = in_row_q + RW'(1);
      in_col_d = '0;
    end else begin
      in_col_d = in_col_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      s1_valid_q <= take;
      byp_q      <= s1_valid_q && (s1_addr_q == in_col_q);
      if (take) begin
        in_row_q <= in_row_d;
        in_col_q <= in_col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_addr_q <= in_col_q;
      s1_pix_q  <= after_frame ? '0 : PW'(pix_i.pixel);
      s1_ctl_q  <= ctl_d;
    end
    byp_data_q <= {rd_mid, s1_pix_q};
  end

  // line store entry: {row two above, row above}; read on a taken pixel, written back the next clock
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_addr_q] <= {rd_mid, s1_pix_q};
    end
    if (take) begin
      rd_data_q <= line_mem[in_col_q];
    end
  end

  // same column written back while being read (single-column frames)
  assign rd_word = byp_q ? byp_data_q : rd_data_q;
  assign rd_top  = rd_word[2*PW-1:PW];
  assign rd_mid  = rd_word[PW-1:0];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = rd_top;
    win_d[1][2] = rd_mid;
    win_d[2][2] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  assign row_en = {s1_ctl_q.bot_en, 1'b1, s1_ctl_q.top_en};
  assign col_en = {s1_ctl_q.right_en, 1'b1, s1_ctl_q.left_en};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        taps[r*3+c] = (row_en[r] && col_en[c]) ? win_d[r][c] : '0;
      end
    end
  end

  assign push_o      = s1_valid_q && s1_ctl_q.emit;
  assign push_data_o = {s1_ctl_q.frame_end, taps};

endmodule

/* rtl/c3zpf_queue.sv */
module c3zpf_queue #(
  parameter int unsigned DW = 9 * c3zpf_pkg::PixelBitsDef + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [DW-1:0]       push_data_i,
  input  logic                pop_i,
  output logic [DW-1:0]       head_o,
  output c3zpf_pkg::q_stat_t  stat_o
);

  localparam int unsigned Depth = c3zpf_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned LvlW  = c3zpf_pkg::QueueLvlW;

  logic [DW-1:0]   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [LvlW-1:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   level_q <= level_q + LvlW'(1);
        2'b01:   level_q <= level_q - LvlW'(1);
        default: level_q <= level_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.level = level_q;
  assign stat_o.empty = level_q == '0;

endmodule

/* rtl/c3zpf_back.sv */
module c3zpf_back #(
  parameter int unsigned PIXEL_BITS = c3zpf_pkg::PixelBitsDef,
  localparam int unsigned DW = 9 * PIXEL_BITS + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          filter_sel_i,
  input  c3zpf_pkg::q_stat_t  q_stat_i,
  input  logic [DW-1:0]       head_i,
  output logic                pop_o,
  c3zpf_res_if.source         res_o
);

  localparam int unsigned PW = PIXEL_BITS;
  // 32 times the largest pixel, plus sign; the kernel sums reach 16 times
  localparam int unsigned SW = PW + 6;
  localparam int unsigned VW = c3zpf_pkg::ValueW;

  logic [8:0][PW-1:0]     taps;
  logic signed [SW-1:0]   px;
  logic signed [SW-1:0]   sum_g, sum_x, sum_y, sum;
  logic signed [VW-1:0]   value_d;
  logic                   out_valid_q;
  logic signed [VW-1:0]   value_q;
  logic                   frame_end_q;

  assign taps  = head_i[9*PW-1:0];
  assign pop_o = !q_stat_i.empty && (!out_valid_q || res_o.ready);

  // fixed taps per kernel fold into shifts and adds
  always_comb begin
    sum_g = '0;
    sum_x = '0;
    sum_y = '0;
    px    = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        px    = SW'(signed'({1'b0, taps[r*3+c]}));
        sum_g = sum_g + px * SW'(c3zpf_pkg::kernel_tap(c3zpf_pkg::FiltGauss, r, c));
        sum_x = sum_x + px * SW'(c3zpf_pkg::kernel_tap(c3zpf_pkg::FiltGradX, r, c));
        sum_y = sum_y + px * SW'(c3zpf_pkg::kernel_tap(c3zpf_pkg::FiltGradY, r, c));
      end
    end
  end

  always_comb begin
    unique case (filter_sel_i)
      c3zpf_pkg::FiltGauss: sum = sum_g;
      c3zpf_pkg::FiltGradX: sum = sum_x;
      c3zpf_pkg::FiltGradY: sum = sum_y;
      default:              sum = '0;
    endcase
  end

  always_comb begin
    if (sum > SW'(c3zpf_pkg::ValueMax)) begin
      value_d = c3zpf_pkg::ValueMax;
    end else if (sum < SW'(c3zpf_pkg::ValueMin)) begin
      value_d = c3zpf_pkg::ValueMin;
    end else begin
      value_d = VW'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      value_q     <= value_d;
      frame_end_q <= head_i[DW-1];
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.value     = value_q;
  assign res_o.frame_end = frame_end_q;

endmodule

/* rtl/conv3x3_zero_pad_filter_unit.sv */
// 3x3 zero-padded image filter. Takes a grayscale frame one pixel per transfer in raster
// order and applies a Gaussian blur (result is 16 times the blur) or a Scharr X or Y
// gradient, chosen by filter_select; pixels outside the frame count as zero. Sustained
// rate is one pixel per clock while results are accepted, set by the single line-store
// access per pixel (one read and one write each clock, write-back forwarded when the same
// column comes straight back). The result for pixel p is started by the transfer that
// follows pixel p + frame_cols and passes the window stage, the queue and the output
// register before it is offered. After the frame's last pixel send frame_cols + 1
// drain transfers to flush the final results; a drain inside the frame is
// dropped. frame_end marks the frame's last result. The line store is not cleared after
// reset: entries not yet written only feed taps above the frame, which are zeroed.
// Write the configuration only while the block is idle.
module conv3x3_zero_pad_filter_unit #(
  parameter int unsigned MAX_COLS   = c3zpf_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS   = c3zpf_pkg::MaxRowsDef,
  parameter int unsigned PIXEL_BITS = c3zpf_pkg::PixelBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [c3zpf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [c3zpf_pkg::CfgW-1:0]      cfg_data_i,
  c3zpf_pix_if.sink                       pix_i,
  c3zpf_res_if.source                     res_o
);

  localparam int unsigned RW   = $clog2(MAX_ROWS + 2);
  localparam int unsigned CNTW = $clog2(MAX_COLS + 1);
  localparam int unsigned DW   = 9 * PIXEL_BITS + 1;

  logic [1:0]                  filter_sel_q;
  logic [c3zpf_pkg::CfgW-1:0]  rows_cfg_q, cols_cfg_q;
  logic [RW-1:0]               rows_eff;
  logic [CNTW-1:0]             cols_eff;

  logic                        push, pop;
  logic [DW-1:0]               push_data, head;
  c3zpf_pkg::q_stat_t          q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_sel_q <= c3zpf_pkg::FilterRst;
      rows_cfg_q   <= c3zpf_pkg::RowsRst;
      cols_cfg_q   <= c3zpf_pkg::ColsRst;
    end else if (cfg_we_i) begin
      unique case (c3zpf_pkg::cfg_reg_e'(cfg_idx_i))
        c3zpf_pkg::RegFilterSel: filter_sel_q <= cfg_data_i[1:0];
        c3zpf_pkg::RegFrameRows: rows_cfg_q   <= cfg_data_i;
        c3zpf_pkg::RegFrameCols: cols_cfg_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize as the maximum
  always_comb begin
    if (rows_cfg_q == '0) begin
      rows_eff = RW'(1);
    end else if (32'(rows_cfg_q) > 32'(MAX_ROWS)) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(rows_cfg_q);
    end
    if (cols_cfg_q == '0) begin
      cols_eff = CNTW'(1);
    end else if (32'(cols_cfg_q) > 32'(MAX_COLS)) begin
      cols_eff = CNTW'(MAX_COLS);
    end else begin
      cols_eff = CNTW'(cols_cfg_q);
    end
  end

  c3zpf_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .rows_i      (rows_eff),
    .cols_i      (cols_eff),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  c3zpf_queue #(
    .DW (DW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  c3zpf_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .filter_sel_i (filter_sel_q),
    .q_stat_i     (q_stat),
    .head_i       (head),
    .pop_o        (pop),
    .res_o        (res_o)
  );

endmodule

/* rtl/c3zpf_checker.sv */
`include "conv3x3_zero_pad_filter_unit_macros.svh"

module c3zpf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic [c3zpf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input logic [c3zpf_pkg::CfgW-1:0]          cfg_data_i,
  input logic                                pix_valid_i,
  input logic                                pix_ready_i,
  input logic                                res_valid_i,
  input logic                                res_ready_i,
  input logic signed [c3zpf_pkg::ValueW-1:0] res_value_i,
  input logic                                res_frame_end_i
);

  logic gauss_q;
  logic seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gauss_q <= c3zpf_pkg::FilterRst == c3zpf_pkg::FiltGauss;
      seen_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == c3zpf_pkg::RegFilterSel) begin
        gauss_q <= cfg_data_i[1:0] == c3zpf_pkg::FiltGauss;
      end
      if (pix_valid_i && pix_ready_i) begin
        seen_q <= 1'b1;
      end
    end
  end

  `C3ZPF_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_value_i) && $stable(res_frame_end_i), "result changed while stalled")
  `C3ZPF_ASSERT(a_gauss_nonneg, (res_valid_i && gauss_q) |-> !res_value_i[c3zpf_pkg::ValueW-1], "negative blur result")
  `C3ZPF_ASSERT(a_no_orphan, res_valid_i |-> seen_q, "result without any pixel transfer")
  `C3ZPF_ASSERT(a_reset_quiet, !$past(rst_ni) |-> !res_valid_i, "result straight out of reset")

endmodule

bind conv3x3_zero_pad_filter_unit c3zpf_checker u_c3zpf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .cfg_idx_i       (cfg_idx_i),
  .cfg_data_i      (cfg_data_i),
  .pix_valid_i     (pix_i.valid),
  .pix_ready_i     (pix_i.ready),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_value_i     (res_o.value),
  .res_frame_end_i (res_o.frame_end)
);
